### design/hot_key_counter_table_top_defines.svh
// Assertion macros shared by the hot key counter table design.
`ifndef HOT_KEY_COUNTER_TABLE_TOP_DEFINES_SVH
`define HOT_KEY_COUNTER_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, quiet during reset.
`define HKCT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkct assertion failed");

// Next-cycle implication, quiet during reset.
`define HKCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkct assertion failed");

`else

`define HKCT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define HKCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/hkct_pkg.sv
package hkct_pkg;

  localparam int KEY_W             = 64;
  localparam int COUNT_W           = 32;
  localparam int SLOT_OUT_W        = 12;
  localparam int HOME_SHIFT        = 3;
  localparam int HOME_DIGIT_W      = 4;
  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int DEF_PROBE_LIMIT   = 8;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;

  localparam count_t COUNT_MAX    = '1;
  localparam count_t THRESH_RESET = COUNT_W'(2);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_COUNTED  = 2'd1,
    ST_SKIPPED  = 2'd2,
    ST_ZERO_KEY = 2'd3
  } status_t;

endpackage

### design/hkct_in_if.sv
interface hkct_in_if;
  import hkct_pkg::*;

  logic valid;
  logic ready;
  key_t method_key;

  modport source (output valid, output method_key, input ready);
  modport sink   (input valid, input method_key, output ready);
endinterface

### design/hkct_out_if.sv
interface hkct_out_if;
  import hkct_pkg::*;

  logic      valid;
  logic      ready;
  status_t   status;
  logic      compile_request;
  count_t    entry_count;
  slot_out_t slot_index;

  modport source (output valid, output status, output compile_request,
                  output entry_count, output slot_index, input ready);
  modport sink   (input valid, input status, input compile_request,
                  input entry_count, input slot_index, output ready);
endinterface

### design/hkct_home_unit.sv
module hkct_home_unit #(
  parameter int ENTRIES = hkct_pkg::DEF_TABLE_ENTRIES,
  parameter int IDX_W   = $clog2(hkct_pkg::DEF_TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hkct_pkg::key_t     key,
  output logic               done,
  output logic [IDX_W-1:0]   home
);
  import hkct_pkg::*;

  localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      logic             done_r;
      logic [IDX_W-1:0] home_r;

      // Power-of-two table: the home slot is a bit field of the key.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          home_r <= key[HOME_SHIFT +: IDX_W];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_serial
      localparam int SHIFTED_W = KEY_W - HOME_SHIFT;
      localparam int DIGITS    = (SHIFTED_W + HOME_DIGIT_W - 1) / HOME_DIGIT_W;
      localparam int PAD_W     = DIGITS * HOME_DIGIT_W;
      localparam int CNT_W     = $clog2(DIGITS + 1);

      logic [PAD_W-1:0] shreg_r;
      logic [IDX_W:0]   rem_r, rem_nxt;
      logic [CNT_W-1:0] left_r;
      logic             busy_r;
      logic             done_r;

      // Restoring remainder, a few key bits per cycle, most significant first.
      always_comb begin
        rem_nxt = rem_r;
        for (int i = 0; i < HOME_DIGIT_W; i++) begin
          rem_nxt = {rem_nxt[IDX_W-1:0], shreg_r[PAD_W-1-i]};
          if (rem_nxt >= (IDX_W+1)'(ENTRIES)) begin
            rem_nxt = rem_nxt - (IDX_W+1)'(ENTRIES);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r  <= 1'b1;
            shreg_r <= PAD_W'(key >> HOME_SHIFT);
            rem_r   <= '0;
            left_r  <= CNT_W'(DIGITS);
          end else if (busy_r) begin
            shreg_r <= shreg_r << HOME_DIGIT_W;
            rem_r   <= rem_nxt;
            left_r  <= left_r - CNT_W'(1);
            if (left_r == CNT_W'(1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      assign done = done_r;
      assign home = rem_r[IDX_W-1:0];
    end
  endgenerate

endmodule

### design/hkct_table_mem.sv
module hkct_table_mem #(
  parameter int ENTRIES = hkct_pkg::DEF_TABLE_ENTRIES,
  parameter int IDX_W   = $clog2(hkct_pkg::DEF_TABLE_ENTRIES),
  parameter int WORD_W  = hkct_pkg::KEY_W + hkct_pkg::COUNT_W
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/hot_key_counter_table_top.sv
// Flow: the home slot is taken from the key (a bit field for a power-of-two table, a serial
//   reduction for other sizes), then up to PROBE_LIMIT slots are probed; zero key: no probe.
// Throughput: one transaction at a time; each probe reads its slot on the single table read
//   port, then checks it. The next key is taken once the result is in the output register.
// Reset: a clearing sweep over all TABLE_ENTRIES slots empties the table, ready stays low
//   meanwhile; the threshold register returns to 2.
`include "hot_key_counter_table_top_defines.svh"

module hot_key_counter_table_top #(
  parameter int TABLE_ENTRIES = hkct_pkg::DEF_TABLE_ENTRIES,
  parameter int PROBE_LIMIT   = hkct_pkg::DEF_PROBE_LIMIT
) (
  input  logic             clk,
  input  logic             rst_n,
  hkct_in_if.sink          in_ch,
  hkct_out_if.source       out_ch,
  input  logic             cfg_we,
  input  hkct_pkg::count_t cfg_wdata
);
  import hkct_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int LEFT_W  = $clog2(PROBE_LIMIT + 1);
  localparam int WORD_W  = KEY_W + COUNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    clr_addr_r;
  key_t                key_r;
  logic [IDX_W-1:0]    slot_r;
  logic [IDX_W-1:0]    slot_nxt;
  logic [LEFT_W-1:0]   left_r;
  count_t              thr_r;

  // Result of the current transaction, held until the output register is free.
  status_t             res_status_r;
  logic                res_req_r;
  count_t              res_count_r;
  logic [IDX_W-1:0]    res_slot_r;

  // Output register.
  logic                out_valid_r;
  status_t             out_status_r;
  logic                out_req_r;
  count_t              out_count_r;
  slot_out_t           out_slot_r;

  // Home-slot unit and table port.
  logic                home_start;
  logic                home_done;
  logic [IDX_W-1:0]    home;
  logic                mem_rd_en;
  logic [WORD_W-1:0]   mem_rd_data;
  logic                mem_wr_en;
  logic [IDX_W-1:0]    mem_wr_addr;
  logic [WORD_W-1:0]   mem_wr_data;

  // Probe evaluation.
  key_t                rd_key;
  count_t              rd_cnt;
  logic                hit;
  logic                empty;
  logic                sat;
  count_t              cnt_inc;
  count_t              thr_eff;
  logic                raised;
  count_t              new_count;

  hkct_home_unit #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (in_ch.method_key),
    .done  (home_done),
    .home  (home)
  );

  hkct_table_mem #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W),
    .WORD_W  (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (slot_r),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign home_start  = (state_r == S_IDLE) && in_ch.valid && (in_ch.method_key != '0);

  // A zero threshold behaves as one.
  assign thr_eff = (thr_r == '0) ? COUNT_W'(1) : thr_r;

  // Compare the slot just read against the key under probe.
  assign rd_key    = mem_rd_data[WORD_W-1 -: KEY_W];
  assign rd_cnt    = mem_rd_data[COUNT_W-1:0];
  assign hit       = (rd_key == key_r);
  assign empty     = (rd_key == '0);
  assign sat       = (rd_cnt == COUNT_MAX);
  assign cnt_inc   = sat ? rd_cnt : rd_cnt + COUNT_W'(1);
  assign raised    = !sat && (cnt_inc == thr_eff);
  assign new_count = hit ? cnt_inc : COUNT_W'(1);

  // Advance to the next slot, wrapping at the end of the table.
  assign slot_nxt = (slot_r == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : slot_r + IDX_W'(1);

  // Write port: the clearing sweep owns it after reset, then the
  // probe writes back a hit or an insert.
  assign mem_rd_en   = (state_r == S_READ);
  assign mem_wr_en   = (state_r == S_CLEAR) || ((state_r == S_CHECK) && (hit || empty));
  assign mem_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : slot_r;
  assign mem_wr_data = (state_r == S_CLEAR) ? '0 : {key_r, new_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THRESH_RESET;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end

      // Drop the result once the sink takes it; in S_DONE the load below decides.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + IDX_W'(1);
          if (clr_addr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            key_r <= in_ch.method_key;
            if (in_ch.method_key == '0) begin
              res_status_r <= ST_ZERO_KEY;
              res_req_r    <= 1'b0;
              res_count_r  <= '0;
              res_slot_r   <= '0;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (home_done) begin
            slot_r  <= home;
            left_r  <= LEFT_W'(PROBE_LIMIT);
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          priority if (hit) begin
            res_status_r <= ST_COUNTED;
            res_req_r    <= raised;
            res_count_r  <= cnt_inc;
            res_slot_r   <= slot_r;
            state_r      <= S_DONE;
          end else if (empty) begin
            res_status_r <= ST_INSERTED;
            res_req_r    <= 1'b0;
            res_count_r  <= COUNT_W'(1);
            res_slot_r   <= slot_r;
            state_r      <= S_DONE;
          end else if (left_r == LEFT_W'(1)) begin
            res_status_r <= ST_SKIPPED;
            res_req_r    <= 1'b0;
            res_count_r  <= '0;
            res_slot_r   <= '0;
            state_r      <= S_DONE;
          end else begin
            slot_r  <= slot_nxt;
            left_r  <= left_r - LEFT_W'(1);
            state_r <= S_READ;
          end
        end
        S_DONE: begin
          // Hold until the output register is free or being emptied.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_req_r    <= res_req_r;
            out_count_r  <= res_count_r;
            out_slot_r   <= SLOT_OUT_W'(res_slot_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.compile_request = out_req_r;
  assign out_ch.entry_count     = out_count_r;
  assign out_ch.slot_index      = out_slot_r;

  `HKCT_ASSERT_IMPLIES(a_miss_fields_zero, clk, rst_n,
    out_ch.valid && (out_ch.status == ST_SKIPPED || out_ch.status == ST_ZERO_KEY),
    out_ch.entry_count == '0 && out_ch.slot_index == '0 && !out_ch.compile_request)
  `HKCT_ASSERT_IMPLIES(a_request_only_counted, clk, rst_n,
    out_ch.valid && out_ch.compile_request, out_ch.status == ST_COUNTED)
  `HKCT_ASSERT_IMPLIES(a_insert_count_one, clk, rst_n,
    out_ch.valid && out_ch.status == ST_INSERTED, out_ch.entry_count == COUNT_W'(1))
  `HKCT_ASSERT_IMPLIES(a_home_in_range, clk, rst_n,
    home_done, (IDX_W+1)'(home) < (IDX_W+1)'(TABLE_ENTRIES))
  `HKCT_ASSERT_NEXT(a_write_ends_probe, clk, rst_n,
    state_r == S_CHECK && mem_wr_en, state_r == S_DONE)

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hkct_pkg::*;

  // Geometry of the instance under test (default parameters).
  localparam int unsigned SLOTS        = DEF_TABLE_ENTRIES;
  localparam int unsigned PROBES       = DEF_PROBE_LIMIT;
  localparam int unsigned HOME_W       = 12;
  localparam int unsigned PHASE_ITEMS  = 225;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 700;
  localparam int unsigned SETTLE_TICKS = 40;
  localparam int unsigned MAX_REPORTS  = 40;
  // Run time limit in ns, with a wide margin over the slowest run and the clearing sweep.
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;

  typedef struct packed {
    status_t   status;
    logic      compile_request;
    count_t    entry_count;
    slot_out_t slot_index;
  } table_outcome_t;

  // Mirror of the hash counter table: updates its own copy of the slots on every
  // accepted key and queues the outcome the block must return for it.
  class key_count_tracker;
    key_t           slot_key   [SLOTS];
    count_t         slot_count [SLOTS];
    count_t         threshold;
    table_outcome_t pending_outcomes[$];
    int unsigned    mismatches;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i]   = '0;
        slot_count[i] = '0;
      end
      threshold  = THRESH_RESET;
      mismatches = 0;
    endfunction

    function void set_threshold(count_t value);
      threshold = value;
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction

    function void take_key(key_t key);
      table_outcome_t res;
      count_t         thr;
      int unsigned    home;
      int unsigned    s;
      int unsigned    p;
      bit             done;
      res.status          = ST_SKIPPED;
      res.compile_request = 1'b0;
      res.entry_count     = '0;
      res.slot_index      = '0;
      thr  = (threshold == '0) ? count_t'(1) : threshold;
      done = 1'b0;
      if (key == '0) begin
        res.status = ST_ZERO_KEY;
      end else begin
        home = 32'((key >> HOME_SHIFT) % SLOTS);
        for (p = 0; p < PROBES && !done; p++) begin
          s = (home + p) % SLOTS;
          if (slot_key[s] == key) begin
            // saturated count stays put and raises nothing
            if (slot_count[s] != COUNT_MAX) begin
              slot_count[s]       = slot_count[s] + 1;
              res.compile_request = (slot_count[s] == thr);
            end
            res.status      = ST_COUNTED;
            res.entry_count = slot_count[s];
            res.slot_index  = slot_out_t'(s);
            done            = 1'b1;
          end else if (slot_key[s] == '0) begin
            slot_key[s]     = key;
            slot_count[s]   = count_t'(1);
            res.status      = ST_INSERTED;
            res.entry_count = count_t'(1);
            res.slot_index  = slot_out_t'(s);
            done            = 1'b1;
          end
        end
      end
      pending_outcomes.push_back(res);
    endfunction

    function void note_error();
      mismatches++;
    endfunction

    function void check_outcome(table_outcome_t got);
      table_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        note_error();
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got status %0d count %0d slot %0d",
                   $time, got.status, got.entry_count, got.slot_index);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status != want.status) begin
        note_error();
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, got.status);
      end
      if (got.compile_request !== want.compile_request) begin
        note_error();
        if (mismatches <= MAX_REPORTS)
          $display("%0t: compile_request mismatch, expected %0b, got %0b",
                   $time, want.compile_request, got.compile_request);
      end
      if (got.entry_count !== want.entry_count) begin
        note_error();
        if (mismatches <= MAX_REPORTS)
          $display("%0t: entry_count mismatch, expected %0d, got %0d",
                   $time, want.entry_count, got.entry_count);
      end
      if (got.slot_index !== want.slot_index) begin
        note_error();
        if (mismatches <= MAX_REPORTS)
          $display("%0t: slot_index mismatch, expected %0d, got %0d",
                   $time, want.slot_index, got.slot_index);
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;

  hkct_in_if  in_ch();
  hkct_out_if out_ch();

  key_count_tracker board = new();

  table_outcome_t seen_outcome;
  int unsigned    results_seen = 0;
  bit             long_hold_done = 1'b0;
  // Sender pacing: bursts of random length separated by random gaps.
  bit             pace_bursts = 1'b0;
  int unsigned    burst_left = 0;

  hot_key_counter_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("hot_key_counter_table_top test failed");
    $finish;
  end

  // Sample every result transaction at the clock edge and check it against the
  // oldest queued outcome.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_outcome.status          = out_ch.status;
      seen_outcome.compile_request = out_ch.compile_request;
      seen_outcome.entry_count     = out_ch.entry_count;
      seen_outcome.slot_index      = out_ch.slot_index;
      board.check_outcome(seen_outcome);
      results_seen++;
    end
  end

  // Result side back-pressure. Cycle through three modes (always ready, coin
  // flip, sparse periodic ready), each for a random stretch. Once, midway through
  // the run, hold ready low for a long stretch so the output register stays full
  // and the block must stall its input while the sender keeps offering keys.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(2, 0);
        mode_left = $urandom_range(200, 40);
      end
      mode_left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(1, 0));
        default: out_ch.ready <= (tick % 5 == 0);
      endcase
    end
  end

  // Offer one key and hold it until the block takes it; then record the
  // transaction in the tracker and, when pacing is on, insert an idle gap at
  // the end of each burst.
  task automatic offer_key(input key_t key);
    in_ch.valid      <= 1'b1;
    in_ch.method_key <= key;
    do @(posedge clk); while (!in_ch.ready);
    board.take_key(key);
    if (pace_bursts) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
        burst_left = $urandom_range(20, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait until every outstanding key has produced its result.
  // Every key yields exactly one result, so the block is idle afterwards.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input count_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_threshold(value);
  endtask

  // Key with a chosen home slot and a given tag in the upper bits.
  function automatic key_t home_key(input int unsigned tag, input int unsigned home);
    return (key_t'(tag) << (HOME_SHIFT + HOME_W)) | (key_t'(home % SLOTS) << HOME_SHIFT);
  endfunction

  // Random key that lands on a chosen home slot.
  function automatic key_t clustered_key(input int unsigned home);
    key_t k;
    k = {$urandom, $urandom};
    k[HOME_SHIFT +: HOME_W] = HOME_W'(home % SLOTS);
    if (k == '0)
      k[KEY_W-1] = 1'b1;
    return k;
  endfunction

  // Directed keys at the reset threshold of two: zero key, extreme keys, a
  // cluster on the last slot that wraps to the start of the table and then
  // overflows its probe window, and repeats that hit the threshold.
  task automatic run_directed();
    int unsigned t;
    offer_key('0);
    repeat (3) offer_key('1);
    // seven more keys homed on the last slot fill slots 0..6 after the wrap
    for (t = 1; t <= PROBES - 1; t++)
      offer_key(home_key(t, SLOTS - 1));
    // window of eight is now full: skip
    offer_key(home_key(PROBES, SLOTS - 1));
    offer_key(home_key(1, SLOTS - 1));
    offer_key(home_key(PROBES, SLOTS - 1));
    // home slot 0: one free slot left at 7, then the window is full
    offer_key(key_t'(1));
    offer_key({1'b1, {(KEY_W-1){1'b0}}});
    offer_key({(KEY_W/2){2'b01}});
    offer_key({(KEY_W/2){2'b10}});
    offer_key({(KEY_W/2){2'b01}});
    offer_key('0);
  endtask

  // One random phase: set the threshold while idle, build a pool of keys that
  // crowd a narrow band of home slots, then mostly replay pool keys so counts
  // climb through the threshold and probe windows overflow. Mix in fresh random
  // keys, zero keys and near-miss keys with one bit flipped.
  task automatic run_phase(input count_t thr, input int unsigned base, input bit bursty);
    key_t        pool[32];
    key_t        k;
    int unsigned r;
    drain();
    write_threshold(thr);
    pace_bursts = bursty;
    burst_left  = 0;
    foreach (pool[i])
      pool[i] = clustered_key(base + $urandom_range(11, 0));
    repeat (PHASE_ITEMS) begin
      r = $urandom_range(99, 0);
      if (r < 85)
        k = pool[$urandom_range(31, 0)];
      else if (r < 92)
        k = {$urandom, $urandom};
      else if (r < 95)
        k = '0;
      else
        k = pool[$urandom_range(31, 0)] ^ (key_t'(1) << $urandom_range(KEY_W - 1, 0));
      offer_key(k);
    end
  endtask

  // Main sequence: reset, directed keys, then phases over a spread of
  // thresholds including one, the maximum and zero (which acts as one).
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.method_key <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    rst_n            <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ready stays low through the clearing sweep; offer_key waits it out
    run_directed();

    run_phase(count_t'(1),        $urandom_range(SLOTS - 1, 0), 1'b1);
    run_phase(COUNT_MAX,          SLOTS - 6,                    1'b0);
    run_phase('0,                 $urandom_range(SLOTS - 1, 0), 1'b1);
    run_phase(count_t'(3),        $urandom_range(SLOTS - 1, 0), 1'b1);
    run_phase(count_t'($urandom_range(8, 2)), $urandom_range(SLOTS - 1, 0), 1'b1);
    run_phase(count_t'(32'h8000_0000), $urandom_range(SLOTS - 1, 0), 1'b0);
    run_phase(count_t'(4),        SLOTS - 4,                    1'b1);
    run_phase(THRESH_RESET,       $urandom_range(SLOTS - 1, 0), 1'b1);

    // wait out the last results, then give the block time to show any strays
    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (board.mismatches == 0)
      $display("hot_key_counter_table_top test passed");
    else
      $display("hot_key_counter_table_top test failed");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/hkct_pkg.sv
design/hkct_in_if.sv
design/hkct_out_if.sv
design/hkct_home_unit.sv
design/hkct_table_mem.sv
design/hot_key_counter_table_top.sv
tb/testbench.sv
